// ----- sv/lcdt_pkg.sv -----
// Shared types and constants of the LCD timing register block.
`timescale 1ns / 1ps

package lcdt_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_IDLE  = 2'd3
    } cmd_t;

    // Register addresses on the I/O page.
    localparam logic [7:0] ADDR_LCDC = 8'h40;
    localparam logic [7:0] ADDR_STAT = 8'h41;
    localparam logic [7:0] ADDR_SCY  = 8'h42;
    localparam logic [7:0] ADDR_SCX  = 8'h43;
    localparam logic [7:0] ADDR_LY   = 8'h44;
    localparam logic [7:0] ADDR_LYC  = 8'h45;
    localparam logic [7:0] ADDR_DMA  = 8'h46;
    localparam logic [7:0] ADDR_BGP  = 8'h47;
    localparam logic [7:0] ADDR_OBP0 = 8'h48;
    localparam logic [7:0] ADDR_OBP1 = 8'h49;
    localparam logic [7:0] ADDR_WY   = 8'h4A;
    localparam logic [7:0] ADDR_WX   = 8'h4B;
    localparam logic [7:0] ADDR_VBK  = 8'h4F;

    // STAT mode codes.
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam int          DOT_W         = 10;
    localparam logic [9:0]  LINE_CYCLES   = 10'd456;
    localparam logic [9:0]  MODE2_LAST    = 10'd79;
    localparam logic [9:0]  MODE3_LAST    = 10'd251;
    localparam logic [9:0]  DOT_MAX       = 10'd1023;
    localparam logic [7:0]  VISIBLE_LINES = 8'd144;
    localparam logic [7:0]  TOTAL_LINES   = 8'd154;

    localparam logic [7:0]  LCDC_RESET    = 8'h91;
    localparam logic [7:0]  BGP_RESET     = 8'hFC;
    localparam logic [7:0]  OBP_RESET     = 8'hFF;
    localparam logic [7:0]  DMA_READ_VAL  = 8'hFF;
    localparam logic [7:0]  STAT_WR_MASK  = 8'hF8;
    localparam int          LCD_ON_BIT    = 7;
    localparam int          COINC_BIT     = 2;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] port_address;
        logic [7:0] write_data;
        logic [5:0] tick_cycles;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_address;
        logic       vblank_irq;
        logic       render_request;
        logic       dma_go;
        logic [7:0] dma_page;
        logic [1:0] lcd_mode;
        logic [7:0] current_line;
    } result_t;

endpackage

// ----- sv/lcdt_if.sv -----
// Request and result channel interfaces of the LCD timing register block.
`timescale 1ns / 1ps

interface lcdt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] port_address;
    logic [7:0] write_data;
    logic [5:0] tick_cycles;

    modport source (output valid, command, port_address, write_data, tick_cycles,
                    input ready);
    modport sink   (input valid, command, port_address, write_data, tick_cycles,
                    output ready);
endinterface

interface lcdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       bad_address;
    logic       vblank_irq;
    logic       render_request;
    logic       dma_go;
    logic [7:0] dma_page;
    logic [1:0] lcd_mode;
    logic [7:0] current_line;

    modport source (output valid, read_data, bad_address, vblank_irq, render_request,
                    dma_go, dma_page, lcd_mode, current_line,
                    input ready);
    modport sink   (input valid, read_data, bad_address, vblank_irq, render_request,
                    dma_go, dma_page, lcd_mode, current_line,
                    output ready);
endinterface

// ----- sv/lcdt_core.sv -----
// Display register file and line/mode timer, one request per enabled cycle.
`timescale 1ns / 1ps

module lcdt_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             color_mode,
    input  logic             step_en,
    input  lcdt_pkg::item_t  item,
    output lcdt_pkg::result_t result
);

    logic [7:0] lcdc_reg, lcdc_next;
    logic [7:0] stat_reg, stat_next;
    logic [7:0] scy_reg, scy_next;
    logic [7:0] scx_reg, scx_next;
    logic [7:0] ly_reg, ly_next;
    logic [7:0] lyc_reg, lyc_next;
    logic [7:0] bgp_reg, bgp_next;
    logic [7:0] obp0_reg, obp0_next;
    logic [7:0] obp1_reg, obp1_next;
    logic [7:0] wx_reg, wx_next;
    logic [7:0] wy_reg, wy_next;
    logic [7:0] dma_src_reg, dma_src_next;
    logic [7:0] vbk_reg, vbk_next;
    logic [lcdt_pkg::DOT_W-1:0] dot_reg, dot_next;
    logic       dma_pend_reg, dma_pend_next;

    logic [lcdt_pkg::DOT_W:0]   dot_sum;
    logic [lcdt_pkg::DOT_W-1:0] dot_sat;
    logic [7:0]                 ly_inc;

    assign dot_sum = {1'b0, dot_reg} + {{(lcdt_pkg::DOT_W-5){1'b0}}, item.tick_cycles};
    assign dot_sat = dot_sum[lcdt_pkg::DOT_W] ? lcdt_pkg::DOT_MAX
                                              : dot_sum[lcdt_pkg::DOT_W-1:0];
    assign ly_inc  = ly_reg + 8'd1;

    always_comb
    begin
        lcdc_next     = lcdc_reg;
        stat_next     = stat_reg;
        scy_next      = scy_reg;
        scx_next      = scx_reg;
        ly_next       = ly_reg;
        lyc_next      = lyc_reg;
        bgp_next      = bgp_reg;
        obp0_next     = obp0_reg;
        obp1_next     = obp1_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        dma_src_next  = dma_src_reg;
        vbk_next      = vbk_reg;
        dot_next      = dot_reg;
        dma_pend_next = dma_pend_reg;
        result        = '0;

        unique case (item.command)
            lcdt_pkg::CMD_WRITE:
            begin
                unique case (item.port_address)
                    lcdt_pkg::ADDR_LCDC: lcdc_next = item.write_data;
                    lcdt_pkg::ADDR_STAT: stat_next = (item.write_data & lcdt_pkg::STAT_WR_MASK)
                                                   | (stat_reg & ~lcdt_pkg::STAT_WR_MASK);
                    lcdt_pkg::ADDR_SCY:  scy_next  = item.write_data;
                    lcdt_pkg::ADDR_SCX:  scx_next  = item.write_data;
                    lcdt_pkg::ADDR_LY:   ly_next   = '0;
                    lcdt_pkg::ADDR_LYC:  lyc_next  = item.write_data;
                    lcdt_pkg::ADDR_DMA:
                    begin
                        dma_src_next  = item.write_data;
                        dma_pend_next = 1'b1;
                    end
                    lcdt_pkg::ADDR_BGP:  bgp_next  = item.write_data;
                    lcdt_pkg::ADDR_OBP0: obp0_next = item.write_data;
                    lcdt_pkg::ADDR_OBP1: obp1_next = item.write_data;
                    lcdt_pkg::ADDR_WY:   wy_next   = item.write_data;
                    lcdt_pkg::ADDR_WX:   wx_next   = item.write_data;
                    lcdt_pkg::ADDR_VBK:
                    begin
                        // Ignored without a flag when color mode is off.
                        if (color_mode)
                        begin
                            vbk_next = item.write_data;
                        end
                    end
                    default:             result.bad_address = 1'b1;
                endcase
            end
            lcdt_pkg::CMD_READ:
            begin
                unique case (item.port_address)
                    lcdt_pkg::ADDR_LCDC: result.read_data = lcdc_reg;
                    lcdt_pkg::ADDR_STAT: result.read_data = stat_reg;
                    lcdt_pkg::ADDR_SCY:  result.read_data = scy_reg;
                    lcdt_pkg::ADDR_SCX:  result.read_data = scx_reg;
                    lcdt_pkg::ADDR_LY:   result.read_data = ly_reg;
                    lcdt_pkg::ADDR_LYC:  result.read_data = lyc_reg;
                    lcdt_pkg::ADDR_DMA:  result.read_data = lcdt_pkg::DMA_READ_VAL;
                    lcdt_pkg::ADDR_BGP:  result.read_data = bgp_reg;
                    lcdt_pkg::ADDR_OBP0: result.read_data = obp0_reg;
                    lcdt_pkg::ADDR_OBP1: result.read_data = obp1_reg;
                    lcdt_pkg::ADDR_WY:   result.read_data = wy_reg;
                    lcdt_pkg::ADDR_WX:   result.read_data = wx_reg;
                    default:             result.bad_address = 1'b1;
                endcase
            end
            lcdt_pkg::CMD_TICK:
            begin
                if (lcdc_reg[lcdt_pkg::LCD_ON_BIT])
                begin
                    dot_next = dot_sat;
                    if (dma_pend_reg)
                    begin
                        result.dma_go   = 1'b1;
                        result.dma_page = dma_src_reg;
                        dma_pend_next   = 1'b0;
                        dma_src_next    = '0;
                    end

                    if (stat_reg[1:0] == lcdt_pkg::MODE_VBLANK)
                    begin
                        if (dot_sat >= lcdt_pkg::LINE_CYCLES)
                        begin
                            dot_next = dot_sat - lcdt_pkg::LINE_CYCLES;
                            ly_next  = ly_inc;
                            if (ly_inc >= lcdt_pkg::TOTAL_LINES)
                            begin
                                stat_next[1:0] = lcdt_pkg::MODE_HBLANK;
                                ly_next        = '0;
                            end
                            stat_next[lcdt_pkg::COINC_BIT] = (ly_next == lyc_reg);
                        end
                    end
                    else if (dot_sat <= lcdt_pkg::MODE2_LAST)
                    begin
                        stat_next[1:0] = lcdt_pkg::MODE_OAM;
                    end
                    else if (dot_sat <= lcdt_pkg::MODE3_LAST)
                    begin
                        stat_next[1:0]        = lcdt_pkg::MODE_XFER;
                        result.render_request = 1'b1;
                    end
                    else if (dot_sat < lcdt_pkg::LINE_CYCLES)
                    begin
                        stat_next[1:0] = lcdt_pkg::MODE_HBLANK;
                    end
                    else
                    begin
                        dot_next = dot_sat - lcdt_pkg::LINE_CYCLES;
                        ly_next  = ly_inc;
                        if (ly_inc >= lcdt_pkg::VISIBLE_LINES)
                        begin
                            stat_next[1:0]    = lcdt_pkg::MODE_VBLANK;
                            result.vblank_irq = 1'b1;
                        end
                        else
                        begin
                            stat_next[1:0] = lcdt_pkg::MODE_HBLANK;
                        end
                        stat_next[lcdt_pkg::COINC_BIT] = (ly_inc == lyc_reg);
                    end
                end
            end
            lcdt_pkg::CMD_IDLE:
            begin
                result.bad_address = 1'b0;
            end
        endcase

        result.lcd_mode     = stat_next[1:0];
        result.current_line = ly_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg     <= lcdt_pkg::LCDC_RESET;
            stat_reg     <= '0;
            scy_reg      <= '0;
            scx_reg      <= '0;
            ly_reg       <= '0;
            lyc_reg      <= '0;
            bgp_reg      <= lcdt_pkg::BGP_RESET;
            obp0_reg     <= lcdt_pkg::OBP_RESET;
            obp1_reg     <= lcdt_pkg::OBP_RESET;
            wx_reg       <= '0;
            wy_reg       <= '0;
            dma_src_reg  <= '0;
            vbk_reg      <= '0;
            dot_reg      <= '0;
            dma_pend_reg <= 1'b0;
        end
        else if (step_en)
        begin
            lcdc_reg     <= lcdc_next;
            stat_reg     <= stat_next;
            scy_reg      <= scy_next;
            scx_reg      <= scx_next;
            ly_reg       <= ly_next;
            lyc_reg      <= lyc_next;
            bgp_reg      <= bgp_next;
            obp0_reg     <= obp0_next;
            obp1_reg     <= obp1_next;
            wx_reg       <= wx_next;
            wy_reg       <= wy_next;
            dma_src_reg  <= dma_src_next;
            vbk_reg      <= vbk_next;
            dot_reg      <= dot_next;
            dma_pend_reg <= dma_pend_next;
        end
    end

endmodule

// ----- sv/lcd_timing_register_block_core.sv -----
// Top level of the LCD timing register block: input stage, core and result stage.
//
//   channel   | dir | handshake       | carries
//   ----------+-----+-----------------+---------------------------------------
//   req       | in  | valid / ready   | command, port_address, write_data, tick_cycles
//   rsp       | out | valid / ready   | read data, flags, DMA start, mode, line
//   cfg       | in  | cfg_write_en    | color_mode bit
//
// One request per clock is accepted unless stalled; its result is registered.
// The core updates the register file in the cycle the captured request moves
// into the result register, so back-to-back requests see each other's effects.
// A stalled result holds the pipeline; the input stage still takes a request
// while it is empty. Reset is immediate: no clearing pass is needed.
`timescale 1ns / 1ps

module lcd_timing_register_block_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic         cfg_write_data,
    lcdt_in_if.sink      req,
    lcdt_out_if.source   rsp
);

    logic                color_mode_reg;
    logic                s1_valid_reg;
    lcdt_pkg::item_t     s1_item_reg;
    logic                out_valid_reg;
    lcdt_pkg::result_t   out_data_reg;
    lcdt_pkg::result_t   core_result;
    logic                advance;
    logic                fire;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            color_mode_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg.command      <= lcdt_pkg::cmd_t'(req.command);
            s1_item_reg.port_address <= req.port_address;
            s1_item_reg.write_data   <= req.write_data;
            s1_item_reg.tick_cycles  <= req.tick_cycles;
        end
        if (fire)
        begin
            out_data_reg <= core_result;
        end
    end

    lcdt_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .color_mode (color_mode_reg),
        .step_en    (fire),
        .item       (s1_item_reg),
        .result     (core_result)
    );

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = out_data_reg.read_data;
    assign rsp.bad_address    = out_data_reg.bad_address;
    assign rsp.vblank_irq     = out_data_reg.vblank_irq;
    assign rsp.render_request = out_data_reg.render_request;
    assign rsp.dma_go         = out_data_reg.dma_go;
    assign rsp.dma_page       = out_data_reg.dma_page;
    assign rsp.lcd_mode       = out_data_reg.lcd_mode;
    assign rsp.current_line   = out_data_reg.current_line;

endmodule

// ----- sv/lcdt_checker.sv -----
// Port-level checks of the LCD timing register block and their binding.
`timescale 1ns / 1ps

module lcdt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic [7:0] read_data,
    input logic       bad_address,
    input logic       vblank_irq,
    input logic       render_request,
    input logic       dma_go,
    input logic [7:0] dma_page,
    input logic [1:0] lcd_mode,
    input logic [7:0] current_line
);

    // A rejected address never returns data.
    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_address |-> read_data == 8'd0)
        else $error("bad address returned nonzero data");

    a_page_only_on_go: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dma_go |-> dma_page == 8'd0)
        else $error("DMA page shown without a DMA start");

    // Entering vertical blank and the render window both fix the reported mode.
    a_irq_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_irq |-> lcd_mode == lcdt_pkg::MODE_VBLANK
                                    && current_line >= lcdt_pkg::VISIBLE_LINES)
        else $error("vblank pulse outside vertical blank");

    a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && render_request |-> lcd_mode == lcdt_pkg::MODE_XFER)
        else $error("render request outside mode 3");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> current_line < lcdt_pkg::TOTAL_LINES)
        else $error("line counter out of range");

endmodule

bind lcd_timing_register_block_core lcdt_checker u_lcdt_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp.valid),
    .read_data      (rsp.read_data),
    .bad_address    (rsp.bad_address),
    .vblank_irq     (rsp.vblank_irq),
    .render_request (rsp.render_request),
    .dma_go         (rsp.dma_go),
    .dma_page       (rsp.dma_page),
    .lcd_mode       (rsp.lcd_mode),
    .current_line   (rsp.current_line)
);

// ----- tb/tb_lcd_timing_register_block_core.sv -----
// Self-checking testbench of the LCD timing register block: directed and random bus traffic against a predictor.
`timescale 1ns / 1ps

module tb_lcd_timing_register_block_core;

    import lcdt_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int MIXED_REQS  = 120;
    localparam int FRAME_REQS  = 640;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic  cfg_we    = 1'b0;
    logic  cfg_wd    = 1'b0;
    logic  in_valid  = 1'b0;
    logic  out_ready = 1'b0;
    item_t cur_req   = '0;

    lcdt_in_if  req_if ();
    lcdt_out_if rsp_if ();

    assign req_if.valid        = in_valid;
    assign req_if.command      = cur_req.command;
    assign req_if.port_address = cur_req.port_address;
    assign req_if.write_data   = cur_req.write_data;
    assign req_if.tick_cycles  = cur_req.tick_cycles;
    assign rsp_if.ready        = out_ready;

    lcd_timing_register_block_core DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_we),
        .cfg_write_data (cfg_wd),
        .req            (req_if),
        .rsp            (rsp_if)
    );

    always #10 clk = ~clk;

    // Shadow copy of the display registers and the line timer.
    logic       color_mode_q = 1'b0;
    logic [7:0] lcdc_q       = LCDC_RESET;
    logic [7:0] stat_q       = 8'd0;
    logic [7:0] scy_q        = 8'd0;
    logic [7:0] scx_q        = 8'd0;
    logic [7:0] ly_q         = 8'd0;
    logic [7:0] lyc_q        = 8'd0;
    logic [7:0] bgp_q        = BGP_RESET;
    logic [7:0] obp0_q       = OBP_RESET;
    logic [7:0] obp1_q       = OBP_RESET;
    logic [7:0] wy_q         = 8'd0;
    logic [7:0] wx_q         = 8'd0;
    logic [7:0] dma_src_q    = 8'd0;
    logic [7:0] vbk_q        = 8'd0;
    logic [9:0] dots_q       = 10'd0;
    logic       dma_armed    = 1'b0;

    item_t   bus_requests[$];
    result_t lcd_results_due[$];

    int n_errors  = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_vblank  = 0;
    int n_dma     = 0;
    int n_render  = 0;
    int n_bad     = 0;
    int max_line  = 0;

    int gap_left    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    function automatic result_t advance_lcd(item_t rq);
        result_t     r;
        logic [10:0] dot_sum;
        r = '0;
        case (rq.command)
            CMD_WRITE:
            begin
                case (rq.port_address)
                    ADDR_LCDC: lcdc_q = rq.write_data;
                    ADDR_STAT: stat_q = (rq.write_data & STAT_WR_MASK) | (stat_q & ~STAT_WR_MASK);
                    ADDR_SCY:  scy_q  = rq.write_data;
                    ADDR_SCX:  scx_q  = rq.write_data;
                    ADDR_LY:   ly_q   = 8'd0;
                    ADDR_LYC:  lyc_q  = rq.write_data;
                    ADDR_DMA:
                    begin
                        dma_src_q = rq.write_data;
                        dma_armed = 1'b1;
                    end
                    ADDR_BGP:  bgp_q  = rq.write_data;
                    ADDR_OBP0: obp0_q = rq.write_data;
                    ADDR_OBP1: obp1_q = rq.write_data;
                    ADDR_WY:   wy_q   = rq.write_data;
                    ADDR_WX:   wx_q   = rq.write_data;
                    ADDR_VBK:  if (color_mode_q) vbk_q = rq.write_data;
                    default:   r.bad_address = 1'b1;
                endcase
            end
            CMD_READ:
            begin
                case (rq.port_address)
                    ADDR_LCDC: r.read_data = lcdc_q;
                    ADDR_STAT: r.read_data = stat_q;
                    ADDR_SCY:  r.read_data = scy_q;
                    ADDR_SCX:  r.read_data = scx_q;
                    ADDR_LY:   r.read_data = ly_q;
                    ADDR_LYC:  r.read_data = lyc_q;
                    ADDR_DMA:  r.read_data = DMA_READ_VAL;
                    ADDR_BGP:  r.read_data = bgp_q;
                    ADDR_OBP0: r.read_data = obp0_q;
                    ADDR_OBP1: r.read_data = obp1_q;
                    ADDR_WY:   r.read_data = wy_q;
                    ADDR_WX:   r.read_data = wx_q;
                    default:   r.bad_address = 1'b1;
                endcase
            end
            CMD_TICK:
            begin
                if (lcdc_q[LCD_ON_BIT])
                begin
                    dot_sum = {1'b0, dots_q} + rq.tick_cycles;
                    dots_q  = (dot_sum > DOT_MAX) ? DOT_MAX : dot_sum[9:0];
                    if (dma_armed)
                    begin
                        r.dma_go   = 1'b1;
                        r.dma_page = dma_src_q;
                        dma_armed  = 1'b0;
                        dma_src_q  = 8'd0;
                    end
                    if (stat_q[1:0] == MODE_VBLANK)
                    begin
                        // In vertical blank only whole lines are counted; the frame
                        // restarts at line 0 in horizontal blank.
                        if (dots_q >= LINE_CYCLES)
                        begin
                            dots_q = dots_q - LINE_CYCLES;
                            ly_q   = ly_q + 8'd1;
                            if (ly_q >= TOTAL_LINES)
                            begin
                                stat_q[1:0] = MODE_HBLANK;
                                ly_q        = 8'd0;
                            end
                            stat_q[COINC_BIT] = (ly_q == lyc_q);
                        end
                    end
                    else if (dots_q <= MODE2_LAST)
                        stat_q[1:0] = MODE_OAM;
                    else if (dots_q <= MODE3_LAST)
                    begin
                        stat_q[1:0]      = MODE_XFER;
                        r.render_request = 1'b1;
                    end
                    else if (dots_q < LINE_CYCLES)
                        stat_q[1:0] = MODE_HBLANK;
                    else
                    begin
                        dots_q = dots_q - LINE_CYCLES;
                        ly_q   = ly_q + 8'd1;
                        if (ly_q >= VISIBLE_LINES)
                        begin
                            stat_q[1:0]  = MODE_VBLANK;
                            r.vblank_irq = 1'b1;
                        end
                        else
                            stat_q[1:0] = MODE_HBLANK;
                        stat_q[COINC_BIT] = (ly_q == lyc_q);
                    end
                end
            end
            default: ;
        endcase
        r.lcd_mode     = stat_q[1:0];
        r.current_line = ly_q;
        return r;
    endfunction

    // Waits are drawn per request, with quiet stretches where neither side idles.
    function automatic int draw_wait(int count);
        if ((count % 256) < 48)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] pick_reg_addr();
        case ($urandom_range(0, 12))
            0:       return ADDR_LCDC;
            1:       return ADDR_STAT;
            2:       return ADDR_SCY;
            3:       return ADDR_SCX;
            4:       return ADDR_LY;
            5:       return ADDR_LYC;
            6:       return ADDR_DMA;
            7:       return ADDR_BGP;
            8:       return ADDR_OBP0;
            9:       return ADDR_OBP1;
            10:      return ADDR_WY;
            11:      return ADDR_WX;
            default: return ADDR_VBK;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 50)
            $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic push_req(input cmd_t c, input logic [7:0] a, input logic [7:0] d,
                            input logic [5:0] t);
        item_t rq;
        rq.command      = c;
        rq.port_address = a;
        rq.write_data   = d;
        rq.tick_cycles  = t;
        bus_requests.push_back(rq);
    endtask

    // The state is sampled after the edge has settled, so a request that the driver
    // picks up at the same edge is never missed.
    task automatic wait_drained();
        @(posedge clk);
        #1;
        while (bus_requests.size() != 0 || lcd_results_due.size() != 0 || in_valid)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    task automatic set_color_mode(input logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wd <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        color_mode_q = v;
    endtask

    // Request driver: holds a request until it is taken, then waits its drawn gap.
    always @(posedge clk)
    begin
        int gap;
        gap = gap_left;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && req_if.ready)
            begin
                lcd_results_due.push_back(advance_lcd(cur_req));
                n_sent++;
                gap = draw_wait(n_sent);
            end
            if (!(in_valid && !req_if.ready))
            begin
                if (gap == 0 && bus_requests.size() != 0)
                begin
                    cur_req  <= bus_requests.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap > 0)
                        gap--;
                end
            end
        end
        gap_left <= gap;
    end

    // Result monitor with its own random back-pressure.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        int      hold;
        hold = (stall_left > 0) ? stall_left - 1 : 0;
        if (rst_n && rsp_if.valid && out_ready)
        begin
            got.read_data      = rsp_if.read_data;
            got.bad_address    = rsp_if.bad_address;
            got.vblank_irq     = rsp_if.vblank_irq;
            got.render_request = rsp_if.render_request;
            got.dma_go         = rsp_if.dma_go;
            got.dma_page       = rsp_if.dma_page;
            got.lcd_mode       = rsp_if.lcd_mode;
            got.current_line   = rsp_if.current_line;
            if (lcd_results_due.size() == 0)
                report_mismatch("result with no request outstanding", got.current_line, 0);
            else
            begin
                want = lcd_results_due.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.bad_address !== want.bad_address)
                    report_mismatch("bad_address", got.bad_address, want.bad_address);
                if (got.vblank_irq !== want.vblank_irq)
                    report_mismatch("vblank_irq", got.vblank_irq, want.vblank_irq);
                if (got.render_request !== want.render_request)
                    report_mismatch("render_request", got.render_request, want.render_request);
                if (got.dma_go !== want.dma_go)
                    report_mismatch("dma_go", got.dma_go, want.dma_go);
                if (got.dma_page !== want.dma_page)
                    report_mismatch("dma_page", got.dma_page, want.dma_page);
                if (got.lcd_mode !== want.lcd_mode)
                    report_mismatch("lcd_mode", got.lcd_mode, want.lcd_mode);
                if (got.current_line !== want.current_line)
                    report_mismatch("current_line", got.current_line, want.current_line);
                n_vblank += want.vblank_irq;
                n_dma    += want.dma_go;
                n_render += want.render_request;
                n_bad    += want.bad_address;
                if (want.current_line > max_line)
                    max_line = want.current_line;
            end
            n_checked++;
            hold = draw_wait(n_checked);
        end
        stall_left <= hold;
        out_ready  <= (hold == 0);
    end

    // Ends the run if traffic is outstanding but nothing moves for too long.
    always @(posedge clk)
    begin
        if ((bus_requests.size() != 0 || lcd_results_due.size() != 0 || in_valid)
            && !(in_valid && req_if.ready) && !(rsp_if.valid && out_ready))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int         sel;
        logic [7:0] addr;
        logic [7:0] data;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: reset values, register quirks, DMA and a first line.
        set_color_mode(1'b0);
        push_req(CMD_READ,  ADDR_LCDC, 8'd0, 6'd0);
        push_req(CMD_READ,  ADDR_BGP,  8'd0, 6'd0);
        push_req(CMD_READ,  ADDR_OBP1, 8'd0, 6'd0);
        push_req(CMD_READ,  ADDR_DMA,  8'd0, 6'd0);
        push_req(CMD_WRITE, ADDR_STAT, 8'hFF, 6'd0);
        push_req(CMD_READ,  ADDR_STAT, 8'd0, 6'd0);
        push_req(CMD_WRITE, ADDR_VBK,  8'hA5, 6'd0);
        push_req(CMD_READ,  ADDR_VBK,  8'd0, 6'd0);
        push_req(CMD_WRITE, 8'h00,     8'hFF, 6'h3F);
        push_req(CMD_READ,  8'hFF,     8'd0, 6'd0);
        push_req(CMD_WRITE, ADDR_DMA,  8'h00, 6'd0);
        push_req(CMD_TICK,  8'd0,      8'd0, 6'd0);
        push_req(CMD_WRITE, ADDR_LCDC, 8'h00, 6'd0);
        push_req(CMD_WRITE, ADDR_DMA,  8'hFF, 6'd0);
        push_req(CMD_TICK,  8'hFF,     8'hFF, 6'h3F);
        push_req(CMD_WRITE, ADDR_LCDC, 8'hFF, 6'd0);
        // Eight full ticks walk through modes 2, 3 and 0 into the next line.
        repeat (8) push_req(CMD_TICK, 8'd0, 8'd0, 6'h3F);
        push_req(CMD_IDLE,  8'hFF,     8'hFF, 6'h3F);
        push_req(CMD_WRITE, ADDR_LY,   8'hFF, 6'd0);
        push_req(CMD_READ,  ADDR_LY,   8'd0, 6'd0);
        wait_drained();

        // Mixed traffic over all commands and the whole address range.
        set_color_mode(1'b1);
        for (int i = 0; i < MIXED_REQS; i++)
        begin
            sel  = $urandom_range(0, 99);
            addr = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pick_reg_addr();
            if (sel < 45)
                push_req(CMD_TICK, 8'($urandom), 8'($urandom), 6'($urandom));
            else if (sel < 70)
                push_req(CMD_WRITE, addr, 8'($urandom), 6'($urandom));
            else if (sel < 92)
                push_req(CMD_READ, addr, 8'($urandom), 6'($urandom));
            else
                push_req(CMD_IDLE, 8'($urandom), 8'($urandom), 6'($urandom));
        end
        wait_drained();

        // Long ticks with the LCD kept on, enough to run through a whole frame and
        // into the next one. The sender drains completely halfway through.
        set_color_mode(1'b0);
        data             = 8'($urandom);
        data[LCD_ON_BIT] = 1'b1;
        push_req(CMD_WRITE, ADDR_LCDC, data, 6'd0);
        for (int half = 0; half < 2; half++)
        begin
            for (int i = 0; i < FRAME_REQS; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 96)
                    push_req(CMD_TICK, 8'($urandom), 8'($urandom), 6'($urandom_range(56, 63)));
                else
                begin
                    // A line counter reset would keep the frame from completing.
                    addr = pick_reg_addr();
                    if (addr == ADDR_LY)
                        addr = ADDR_LYC;
                    data = 8'($urandom);
                    if (addr == ADDR_LCDC)
                        data[LCD_ON_BIT] = 1'b1;
                    if (addr == ADDR_LYC)
                        data = 8'($urandom_range(0, 153));
                    push_req((sel < 98) ? CMD_WRITE : CMD_READ, addr, data, 6'($urandom));
                end
            end
            wait_drained();
            if (half == 0)
                set_color_mode(1'b1);
        end

        repeat (10) @(posedge clk);
        if (lcd_results_due.size() != 0)
            report_mismatch("results never returned", 0, lcd_results_due.size());

        $display("Ran %0d requests, checked %0d results: %0d bad addresses, %0d DMA starts.",
                 n_sent, n_checked, n_bad, n_dma);
        $display("Saw %0d render ticks, %0d vertical blank entries, highest line %0d.",
                 n_render, n_vblank, max_line);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/lcdt_pkg.sv
sv/lcdt_if.sv
sv/lcdt_core.sv
sv/lcd_timing_register_block_core.sv
sv/lcdt_checker.sv
tb/tb_lcd_timing_register_block_core.sv
